@@ hw/rtl/sgr_enc_pkg.sv @@
// shared types, character codes and colour lookup for the attribute to sgr encoder
package sgr_enc_pkg;

  localparam int unsigned MaxLen  = 14;
  localparam int unsigned IdxW    = 4;

  localparam logic [7:0] EscByte  = 8'h1B;
  localparam logic [7:0] CharLbr  = 8'h5B;
  localparam logic [7:0] CharSemi = 8'h3B;
  localparam logic [7:0] CharM    = 8'h6D;
  localparam logic [7:0] Char0    = 8'h30;
  localparam logic [7:0] Char1    = 8'h31;
  localparam logic [7:0] Char3    = 8'h33;
  localparam logic [7:0] Char4    = 8'h34;
  localparam logic [7:0] Char5    = 8'h35;

  localparam logic [7:0] PlainAttr   = 8'h07;
  localparam logic [7:0] UnknownAttr = 8'hFF;

  typedef struct packed {
    logic                        emit;
    logic [IdxW-1:0]             last_idx;
    logic [MaxLen-1:0][7:0]      bytes;
  } sgr_seq_t;

  // pc colour index to ansi colour digit
  function automatic logic [7:0] colour_char(input logic [2:0] c);
    logic [7:0] r;
    unique case (c)
      3'd0:    r = 8'h30;
      3'd1:    r = 8'h34;
      3'd2:    r = 8'h32;
      3'd3:    r = 8'h36;
      3'd4:    r = 8'h31;
      3'd5:    r = 8'h35;
      3'd6:    r = 8'h33;
      default: r = 8'h37;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/text_attr_to_sgr_encoder_core.sv @@
// top level: input register, attribute state, sequence builder and byte serializer
//
// Converts a stream of pc text attribute bytes into ansi sgr escape bytes.
// Input channel s_axis: tdata carries the attribute, tuser the resync flag
// that forgets the last sent attribute so a full sequence follows.
// Output channel m_axis: one escape byte per transaction, tlast on the
// closing letter m. An attribute equal to the known sent one gives no bytes.
// The first byte of a sequence is offered from the serializer's result
// register, loaded from the input register. A sequence of 3 to 12 bytes
// holds the output register until its last byte is taken, one byte per
// cycle while the receiver is ready; items that give no bytes
// pass at one per cycle. The next item waits in the input register while a
// sequence drains, so the input side is ready again as soon as it moves on.
// Reset clears both registers' valid flags and marks the attribute unknown,
// so the first item always yields a full sequence. When the receiver stalls
// the current byte holds and the input register backs up after one item.
module text_attr_to_sgr_encoder_core import sgr_enc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] new_attr
  input  logic       s_axis_tuser,   // [0] resync
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] attr_q;
  logic       resync_q;
  logic [7:0] sent_q, sent_d;
  logic       known_q, known_d;
  sgr_seq_t   seq;
  logic       load_ready;
  logic       consume;
  logic       load;

  sgr_enc_build u_build (
    .new_attr_i   (attr_q),
    .resync_i     (resync_q),
    .sent_attr_i  (sent_q),
    .attr_known_i (known_q),
    .seq_o        (seq)
  );

  sgr_enc_ser u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .seq_i         (seq),
    .load_ready_o  (load_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // unchanged attributes retire without touching the serializer
  assign consume       = in_valid_q && (!seq.emit || load_ready);
  assign load          = in_valid_q && seq.emit && load_ready;
  assign s_axis_tready = !in_valid_q || consume;

  always_comb begin
    in_valid_d = in_valid_q;
    sent_d     = sent_q;
    known_d    = known_q;
    if (consume) begin
      in_valid_d = 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end
    if (load) begin
      sent_d  = attr_q;
      known_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      sent_q     <= UnknownAttr;
      known_q    <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      sent_q     <= sent_d;
      known_q    <= known_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      attr_q   <= s_axis_tdata;
      resync_q <= s_axis_tuser;
    end
  end

  a_load_starts_esc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> m_axis_tvalid && (m_axis_tdata == EscByte))
    else $error("sequence does not start with escape");

  a_state_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> known_q && (sent_q == $past(attr_q)))
    else $error("sent attribute not updated");

  a_last_is_m: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == CharM)
    else $error("final byte is not m");

  a_skip_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && !seq.emit |=> $stable(sent_q) && known_q)
    else $error("unchanged attribute altered state");

endmodule

@@ hw/rtl/sgr_enc_build.sv @@
// combinational builder of one sgr escape sequence from old and new attribute
module sgr_enc_build import sgr_enc_pkg::*; (
  input  logic [7:0] new_attr_i,
  input  logic       resync_i,
  input  logic [7:0] sent_attr_i,
  input  logic       attr_known_i,
  output sgr_seq_t   seq_o
);

  logic       known;
  logic [7:0] old_attr;
  logic [7:0] base;
  logic       drop;
  logic       set_int;
  logic       set_blink;
  logic       bg_chg;
  logic       fg_chg;

  assign known    = attr_known_i && !resync_i;
  assign old_attr = known ? sent_attr_i : UnknownAttr;
  assign drop     = (old_attr[7] && !new_attr_i[7]) || (old_attr[3] && !new_attr_i[3]);
  assign base     = drop ? PlainAttr : old_attr;
  assign set_int  = new_attr_i[3] && !base[3];
  assign set_blink = new_attr_i[7] && !base[7];
  assign bg_chg   = new_attr_i[6:4] != base[6:4];
  assign fg_chg   = new_attr_i[2:0] != base[2:0];

  always_comb begin
    logic [IdxW-1:0] pos;
    logic            sep;
    seq_o       = '0;
    seq_o.emit  = !(known && (sent_attr_i == new_attr_i));
    seq_o.bytes[0] = EscByte;
    seq_o.bytes[1] = CharLbr;
    pos = IdxW'(2);
    sep = 1'b0;
    if (new_attr_i != PlainAttr) begin
      if (drop) begin
        seq_o.bytes[pos] = Char0;
        pos = pos + 1'b1;
        sep = 1'b1;
      end
      if (set_int) begin
        if (sep) begin
          seq_o.bytes[pos] = CharSemi;
          pos = pos + 1'b1;
        end
        seq_o.bytes[pos] = Char1;
        pos = pos + 1'b1;
        sep = 1'b1;
      end
      if (set_blink) begin
        if (sep) begin
          seq_o.bytes[pos] = CharSemi;
          pos = pos + 1'b1;
        end
        seq_o.bytes[pos] = Char5;
        pos = pos + 1'b1;
        sep = 1'b1;
      end
      if (bg_chg) begin
        if (sep) begin
          seq_o.bytes[pos] = CharSemi;
          pos = pos + 1'b1;
        end
        seq_o.bytes[pos] = Char4;
        pos = pos + 1'b1;
        seq_o.bytes[pos] = colour_char(new_attr_i[6:4]);
        pos = pos + 1'b1;
        sep = 1'b1;
      end
      if (fg_chg) begin
        if (sep) begin
          seq_o.bytes[pos] = CharSemi;
          pos = pos + 1'b1;
        end
        seq_o.bytes[pos] = Char3;
        pos = pos + 1'b1;
        seq_o.bytes[pos] = colour_char(new_attr_i[2:0]);
        pos = pos + 1'b1;
      end
    end
    seq_o.bytes[pos] = CharM;
    seq_o.last_idx   = pos;
  end

endmodule

@@ hw/rtl/sgr_enc_ser.sv @@
// result register holding one sequence, sent out one byte per transaction
module sgr_enc_ser import sgr_enc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  sgr_seq_t   seq_i,
  output logic       load_ready_o,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,
  output logic       m_axis_tlast
);

  logic                   valid_q, valid_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic [IdxW-1:0]        last_idx_q;
  logic [MaxLen-1:0][7:0] bytes_q;
  logic                   xfer;
  logic                   done;

  assign xfer         = valid_q && m_axis_tready;
  assign done         = xfer && (idx_q == last_idx_q);
  assign load_ready_o = !valid_q || done;

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = bytes_q[idx_q];
  assign m_axis_tlast  = idx_q == last_idx_q;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (done) begin
      valid_d = 1'b0;
    end else if (xfer) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q    <= seq_i.bytes;
      last_idx_q <= seq_i.last_idx;
    end
  end

endmodule

@@ sim/tb_top.sv @@
// self-checking testbench for the text attribute to sgr escape encoder
`timescale 1ns / 100ps

module tb_top;
  import sgr_enc_pkg::*;

  typedef struct packed {
    logic [7:0] attr;
    logic       resync;
  } attr_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } sgr_byte_t;

  typedef enum logic [1:0] {
    RdyAlways,
    RdyCoin,
    RdyRare,
    RdyToggle
  } ready_mode_e;

  // colour digit per pc colour index, first character in the top byte
  localparam logic [63:0] ColourDigits = "04261537";
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned HoldAfterItems = 40;
  localparam int unsigned DrainCycles = 20;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] new_attr
  logic       s_axis_tuser = 1'b0;    // [0] resync
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [7:0] out_byte
  logic       m_axis_tlast;

  attr_item_t attr_items_q[$];
  sgr_byte_t  sgr_bytes_q[$];

  // terminal state as the encoder should see it
  logic [7:0] sent_attr_q = UnknownAttr;
  logic       attr_known_q = 1'b0;

  int n_items_total = 0;
  int n_items_accepted = 0;
  int n_errors = 0;

  text_attr_to_sgr_encoder_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [7:0] colour_digit(input logic [2:0] c);
    return ColourDigits[(7 - c) * 8 +: 8];
  endfunction

  function automatic void push_sgr(input logic [7:0] b, input logic l);
    sgr_bytes_q.push_back(sgr_byte_t'{data: b, last: l});
  endfunction

  // expected escape bytes for one attribute change
  function automatic void predict_sgr(input logic [7:0] attr, input logic resync);
    logic [7:0] prev;
    logic       sep;
    if (resync) attr_known_q = 1'b0;
    if (attr_known_q && sent_attr_q == attr) return;
    prev = attr_known_q ? sent_attr_q : UnknownAttr;
    sep = 1'b0;
    push_sgr(EscByte, 1'b0);
    push_sgr(CharLbr, 1'b0);
    if (attr != PlainAttr) begin
      // a dropped blink or intense needs a full reset first
      if ((prev[7] && !attr[7]) || (prev[3] && !attr[3])) begin
        push_sgr(Char0, 1'b0);
        sep = 1'b1;
        prev = PlainAttr;
      end
      if (attr[3] && !prev[3]) begin
        if (sep) push_sgr(CharSemi, 1'b0);
        push_sgr(Char1, 1'b0);
        sep = 1'b1;
      end
      if (attr[7] && !prev[7]) begin
        if (sep) push_sgr(CharSemi, 1'b0);
        push_sgr(Char5, 1'b0);
        sep = 1'b1;
      end
      if (attr[6:4] != prev[6:4]) begin
        if (sep) push_sgr(CharSemi, 1'b0);
        push_sgr(Char4, 1'b0);
        push_sgr(colour_digit(attr[6:4]), 1'b0);
        sep = 1'b1;
      end
      if (attr[2:0] != prev[2:0]) begin
        if (sep) push_sgr(CharSemi, 1'b0);
        push_sgr(Char3, 1'b0);
        push_sgr(colour_digit(attr[2:0]), 1'b0);
      end
    end
    push_sgr(CharM, 1'b1);
    sent_attr_q = attr;
    attr_known_q = 1'b1;
  endfunction

  function automatic void add_item(input logic [7:0] attr, input logic resync);
    attr_items_q.push_back(attr_item_t'{attr: attr, resync: resync});
    n_items_total++;
  endfunction

  // sender: bursts of random length with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) begin
    attr_item_t item;
    logic       busy;
    if (rst_ni) begin
      busy = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_sgr(s_axis_tdata, s_axis_tuser);
        n_items_accepted++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0 || attr_items_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          s_axis_tvalid <= 1'b0;
        end else begin
          item = attr_items_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= item.attr;
          s_axis_tuser <= item.resync;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  // receiver: checks each byte transaction and stalls on its own pattern
  ready_mode_e ready_mode = RdyAlways;
  int          mode_left = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;

  always @(posedge clk_i) begin
    sgr_byte_t exp_b;
    logic      ready_next;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (sgr_bytes_q.size() == 0) begin
          $error("out_byte: none expected, actual %h", m_axis_tdata);
          n_errors++;
        end else begin
          exp_b = sgr_bytes_q.pop_front();
          if (m_axis_tdata !== exp_b.data) begin
            $error("out_byte: expected %h, actual %h", exp_b.data, m_axis_tdata);
            n_errors++;
          end
          if (m_axis_tlast !== exp_b.last) begin
            $error("last_byte: expected %b, actual %b", exp_b.last, m_axis_tlast);
            n_errors++;
          end
        end
      end
      // one long hold-off so the block backs up onto its input
      if (!hold_done && n_items_accepted >= HoldAfterItems) begin
        hold_done = 1'b1;
        hold_left = LongHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = ready_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 80);
        end else begin
          mode_left--;
        end
        case (ready_mode)
          RdyAlways: ready_next = 1'b1;
          RdyCoin:   ready_next = 1'($urandom_range(0, 1));
          RdyRare:   ready_next = ($urandom_range(0, 3) == 0);
          default:   ready_next = !m_axis_tready;
        endcase
      end
      m_axis_tready <= ready_next;
    end
  end

  initial begin
    logic [7:0] last_attr;
    logic [7:0] attr;
    logic       resync;
    int         n_active;
    int         r;

    // directed: plain from unknown, unchanged, extremes, drops and colours
    add_item(PlainAttr, 1'b0);
    add_item(PlainAttr, 1'b0);
    add_item(8'hFF, 1'b0);
    add_item(8'h00, 1'b0);
    add_item(8'h00, 1'b1);
    add_item(8'hFF, 1'b1);
    add_item(8'hFF, 1'b0);
    add_item(8'h00, 1'b0);
    add_item(8'hFE, 1'b0);
    add_item(8'h08, 1'b0);
    add_item(8'h80, 1'b0);
    add_item(8'h87, 1'b0);
    add_item(PlainAttr, 1'b0);
    add_item(PlainAttr, 1'b1);
    for (int i = 0; i < 8; i++) add_item({1'b0, 3'(i), 1'b0, 3'(7 - i)}, 1'b0);
    add_item(8'h8F, 1'b0);
    add_item(8'h70, 1'b0);
    last_attr = 8'h70;

    // random: mostly real changes, some repeats, plain attributes and resyncs
    n_active = 0;
    while (n_active < 90) begin
      r = $urandom_range(0, 99);
      if (r < 20) attr = last_attr;
      else if (r < 30) attr = PlainAttr;
      else if (r < 40) attr = last_attr ^ (8'h01 << $urandom_range(0, 7));
      else attr = 8'($urandom_range(0, 255));
      resync = ($urandom_range(0, 9) == 0);
      add_item(attr, resync);
      if (resync || attr != last_attr) n_active++;
      last_attr = attr;
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_items_accepted != n_items_total) @(posedge clk_i);
    while (sgr_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $error("timeout: %0d items accepted, %0d bytes outstanding",
           n_items_accepted, sgr_bytes_q.size());
    $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/sgr_enc_pkg.sv
hw/rtl/sgr_enc_build.sv
hw/rtl/sgr_enc_ser.sv
hw/rtl/text_attr_to_sgr_encoder_core.sv
sim/tb_top.sv
